// ===== rtl/core/brcn_pkg.sv =====
// Shared types and constants for the bilinear resize and normalize block.
package brcn_pkg;

  localparam int unsigned SRC_BYTES_DEF = 1048576;
  localparam logic [12:0] MAX_SRC_DIM   = 13'd4096;
  localparam logic [10:0] MAX_OUT_SIZE  = 11'd1024;

  localparam int unsigned DIV_W = 58;
  localparam int unsigned Q_W   = 29;
  localparam int unsigned MA_W  = 35;
  localparam int unsigned MB_W  = 17;
  localparam int unsigned MP_W  = MA_W + MB_W;
  localparam int unsigned PIX_W = 29;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_COMPUTE  = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;
  localparam logic [1:0] LAST_CHAN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_MUL,
    ST_CH,
    ST_NORM,
    ST_NCHK,
    ST_DIVN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_OUT_SIZE = 3'd0,
    REG_SRC_W    = 3'd1,
    REG_SRC_H    = 3'd2,
    REG_SRC_CH   = 3'd3,
    REG_MEAN     = 3'd4,
    REG_STD      = 3'd5
  } reg_idx_t;

endpackage

// ===== rtl/core/brcn_ram.sv =====
// Generic simple dual-port RAM with registered read.
module brcn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bilinear_resize_channel_normalize.sv =====
// Bilinear resize with per-channel mean/std normalization, top level.
//
// Input stream: in_tuser selects a byte write (0) or a pixel compute (1).
// A write stores in_tdata's byte in the source memory; writes past
// capacity are dropped and give no result.
// A compute names one output pixel and returns three transfers, channel 0..2,
// out_tlast on channel 2, out_tuser[2] set with value 0 when out of range.
// Steps of a compute: the two scale divisions in the shared restoring
// divider, address and weight products in the shared multiplier, then
// per channel the four memory reads, a normalization setup and a
// normalization division in the same divider (skipped when the value or
// the deviation is zero or the quotient saturates), plus one output
// transfer. An out-of-range compute goes straight to its status transfers.
// in_tready is high only while idle; one item is in flight at a time.
// While out_tready is low the result holds and the sequencer waits.
// Reset (rst_n low, synchronous) returns to idle and loads the register
// defaults; the source memory is not cleared.
// Registers sit on the APB port at byte address 8*index, 64-bit data.
module bilinear_resize_channel_normalize #(
  parameter int unsigned SRC_BYTES = brcn_pkg::SRC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // byte_addr[19:0], byte_value[27:20], out_col[37:28], out_row[47:38]
  input  logic [0:0]  in_tuser,    // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // pixel_value[15:0]
  output logic [2:0]  out_tuser,   // channel[1:0], status[2]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW    = (SRC_BYTES > 1) ? $clog2(SRC_BYTES) : 1;
  localparam int unsigned AD_W  = brcn_pkg::PIX_W;
  localparam int unsigned DIV_W = brcn_pkg::DIV_W;
  localparam int unsigned Q_W   = brcn_pkg::Q_W;
  localparam int unsigned MA_W  = brcn_pkg::MA_W;
  localparam int unsigned MB_W  = brcn_pkg::MB_W;
  localparam int unsigned MP_W  = brcn_pkg::MP_W;

  brcn_pkg::state_t state_r, state_nxt;

  logic [10:0] out_size_r;
  logic [12:0] src_w_r, src_h_r;
  logic [2:0]  src_ch_r;
  logic [47:0] mean_r, std_r;

  logic        in_req;
  logic [19:0] in_addr;
  logic [7:0]  in_byte;
  logic [9:0]  in_col, in_row;
  logic        in_acc, in_bad, cfg_wr;

  logic [10:0] osz;
  logic [12:0] w_eff, h_eff, wm1, hm1;
  logic [2:0]  ch_eff, sc;

  logic [9:0]  col_r, row_r;
  logic [1:0]  chan_r;
  logic        bad_r;
  logic [15:0] out_val_r;
  logic [3:0]  cnt_r;

  logic [DIV_W-1:0] div_r_r, div_d_r, div_rem_nxt;
  logic [Q_W-1:0]   div_q_r, div_q_nxt;
  logic [4:0]       div_cnt_r;
  logic             div_ge;

  logic [Q_W-1:0]  sx_r, sy_r;
  logic [12:0]     x0_r, y0_r, x1, y1;
  logic [15:0]     dx_r, dy_r;
  logic [16:0]     wx0, wx1, wy0, wy1;
  logic [22:0]     xi, yi;
  logic [25:0]     rw0_r, rw1_r;
  logic [32:0]     wgt_r [4];
  logic [AD_W-1:0] nb_r [4];

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MP_W-1:0] mul_r;

  logic [AD_W-1:0] rd_addr_full;
  logic            rd_in, rd_en, oob_d_r, ram_we;
  logic [7:0]      ram_rdata;
  logic [1:0]      wgt_idx;

  logic [40:0] acc_r;
  logic [15:0] mean16, std16;
  logic [23:0] mterm, den24, dn_r;
  logic [41:0] diff;
  logic [40:0] mag;
  logic [53:0] nsum;
  logic        neg, neg_r, mag0_r, den0_r, nsat;
  logic [16:0] qn;
  logic [15:0] qval;

  // input fields
  assign in_req  = in_tuser[0];
  assign in_addr = in_tdata[19:0];
  assign in_byte = in_tdata[27:20];
  assign in_col  = in_tdata[37:28];
  assign in_row  = in_tdata[47:38];

  assign in_tready = (state_r == brcn_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // effective configuration
  assign osz    = (out_size_r > brcn_pkg::MAX_OUT_SIZE) ? brcn_pkg::MAX_OUT_SIZE : out_size_r;
  assign w_eff  = (src_w_r == 13'd0) ? 13'd1 :
                  ((src_w_r > brcn_pkg::MAX_SRC_DIM) ? brcn_pkg::MAX_SRC_DIM : src_w_r);
  assign h_eff  = (src_h_r == 13'd0) ? 13'd1 :
                  ((src_h_r > brcn_pkg::MAX_SRC_DIM) ? brcn_pkg::MAX_SRC_DIM : src_h_r);
  assign ch_eff = (src_ch_r == 3'd0) ? 3'd1 : src_ch_r;
  assign wm1    = w_eff - 13'd1;
  assign hm1    = h_eff - 13'd1;
  assign sc     = ({1'b0, chan_r} < (ch_eff - 3'd1)) ? {1'b0, chan_r} : (ch_eff - 3'd1);

  assign in_bad = (osz == 11'd0) || ({1'b0, in_col} >= osz) || ({1'b0, in_row} >= osz);

  // shared divider step
  assign div_ge      = (div_r_r >= div_d_r);
  assign div_rem_nxt = div_ge ? (div_r_r - div_d_r) : div_r_r;
  assign div_q_nxt   = {div_q_r[Q_W-2:0], div_ge};

  // neighbor positions and weights
  assign xi  = mul_r[38:16];
  assign yi  = mul_r[38:16];
  assign x1  = (x0_r >= wm1) ? wm1 : (x0_r + 13'd1);
  assign y1  = (y0_r >= hm1) ? hm1 : (y0_r + 13'd1);
  assign wx0 = 17'h10000 - {1'b0, dx_r};
  assign wx1 = {1'b0, dx_r};
  assign wy0 = 17'h10000 - {1'b0, dy_r};
  assign wy1 = {1'b0, dy_r};

  // memory access
  assign rd_addr_full = nb_r[cnt_r[1:0]] + {{(AD_W-3){1'b0}}, sc};
  assign rd_in        = (rd_addr_full < AD_W'(SRC_BYTES));
  assign rd_en        = (state_r == brcn_pkg::ST_CH) && (cnt_r < 4'd4);
  assign ram_we       = in_acc && (in_req == brcn_pkg::REQ_WRITE) &&
                        ({9'b0, in_addr} < AD_W'(SRC_BYTES));
  assign wgt_idx      = 2'(cnt_r - 4'd1);

  brcn_ram #(
    .WIDTH (8),
    .DEPTH (SRC_BYTES)
  ) u_src_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(in_addr)),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_full[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // normalization front end
  always_comb begin
    unique case (chan_r)
      2'd0: begin
        mean16 = mean_r[15:0];
        std16  = std_r[15:0];
      end
      2'd1: begin
        mean16 = mean_r[31:16];
        std16  = std_r[31:16];
      end
      default: begin
        mean16 = mean_r[47:32];
        std16  = std_r[47:32];
      end
    endcase
  end

  assign mterm = {mean16, 8'b0} - {8'b0, mean16};
  assign den24 = {std16, 8'b0} - {8'b0, std16};
  assign diff  = {1'b0, acc_r} - {2'b0, mterm, 16'b0};
  assign neg   = diff[41];
  assign mag   = neg ? 41'(-diff) : diff[40:0];
  assign nsum  = {1'b0, mag, 12'b0} + {15'b0, den24, 15'b0};
  assign nsat  = (div_r_r >= {1'b0, dn_r, 33'b0});

  assign qn   = div_q_nxt[16:0];
  assign qval = neg_r ? ((qn > 17'd32768) ? 16'h8000 : 16'(-qn))
                      : ((qn > 17'd32767) ? 16'h7FFF : qn[15:0]);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == brcn_pkg::ST_MUL) begin
      unique case (cnt_r)
        4'd0: begin
          mul_a = {6'b0, sx_r};
          mul_b = {7'b0, col_r};
        end
        4'd1: begin
          mul_a = {6'b0, sy_r};
          mul_b = {7'b0, row_r};
        end
        4'd3: begin
          mul_a = {22'b0, w_eff};
          mul_b = {4'b0, y0_r};
        end
        4'd4: begin
          mul_a = {22'b0, w_eff};
          mul_b = {4'b0, y1};
        end
        4'd5: begin
          mul_a = {18'b0, wx0};
          mul_b = wy0;
        end
        4'd6: begin
          mul_a = {18'b0, wx1};
          mul_b = wy0;
        end
        4'd7: begin
          mul_a = {18'b0, wx0};
          mul_b = wy1;
        end
        4'd8: begin
          mul_a = {18'b0, wx1};
          mul_b = wy1;
        end
        4'd9: begin
          mul_a = {9'b0, rw0_r + {13'b0, x0_r}};
          mul_b = {14'b0, ch_eff};
        end
        4'd10: begin
          mul_a = {9'b0, rw0_r + {13'b0, x1}};
          mul_b = {14'b0, ch_eff};
        end
        4'd11: begin
          mul_a = {9'b0, rw1_r + {13'b0, x0_r}};
          mul_b = {14'b0, ch_eff};
        end
        4'd12: begin
          mul_a = {9'b0, rw1_r + {13'b0, x1}};
          mul_b = {14'b0, ch_eff};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if ((state_r == brcn_pkg::ST_CH) && (cnt_r >= 4'd1) && (cnt_r <= 4'd4)) begin
      mul_a = {2'b0, wgt_r[wgt_idx]};
      mul_b = oob_d_r ? 17'd0 : {9'b0, ram_rdata};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brcn_pkg::ST_IDLE: begin
        if (in_acc && (in_req == brcn_pkg::REQ_COMPUTE)) begin
          state_nxt = in_bad ? brcn_pkg::ST_OUT : brcn_pkg::ST_DIVX;
        end
      end
      brcn_pkg::ST_DIVX: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = brcn_pkg::ST_DIVY;
        end
      end
      brcn_pkg::ST_DIVY: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = brcn_pkg::ST_MUL;
        end
      end
      brcn_pkg::ST_MUL: begin
        if (cnt_r == 4'd13) begin
          state_nxt = brcn_pkg::ST_CH;
        end
      end
      brcn_pkg::ST_CH: begin
        if (cnt_r == 4'd5) begin
          state_nxt = brcn_pkg::ST_NORM;
        end
      end
      brcn_pkg::ST_NORM: begin
        state_nxt = brcn_pkg::ST_NCHK;
      end
      brcn_pkg::ST_NCHK: begin
        state_nxt = (mag0_r || den0_r || nsat) ? brcn_pkg::ST_OUT : brcn_pkg::ST_DIVN;
      end
      brcn_pkg::ST_DIVN: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = brcn_pkg::ST_OUT;
        end
      end
      brcn_pkg::ST_OUT: begin
        if (out_tready) begin
          if (chan_r == brcn_pkg::LAST_CHAN) begin
            state_nxt = brcn_pkg::ST_IDLE;
          end else begin
            state_nxt = bad_r ? brcn_pkg::ST_OUT : brcn_pkg::ST_CH;
          end
        end
      end
      default: state_nxt = brcn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= brcn_pkg::ST_IDLE;
      out_size_r <= 11'd224;
      src_w_r    <= 13'd1;
      src_h_r    <= 13'd1;
      src_ch_r   <= 3'd3;
      mean_r     <= '0;
      std_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (brcn_pkg::reg_idx_t'(cfg_paddr[5:3]))
          brcn_pkg::REG_OUT_SIZE: out_size_r <= cfg_pwdata[10:0];
          brcn_pkg::REG_SRC_W:    src_w_r    <= cfg_pwdata[12:0];
          brcn_pkg::REG_SRC_H:    src_h_r    <= cfg_pwdata[12:0];
          brcn_pkg::REG_SRC_CH:   src_ch_r   <= cfg_pwdata[2:0];
          brcn_pkg::REG_MEAN:     mean_r     <= cfg_pwdata[47:0];
          brcn_pkg::REG_STD:      std_r      <= cfg_pwdata[47:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (brcn_pkg::reg_idx_t'(cfg_paddr[5:3]))
      brcn_pkg::REG_OUT_SIZE: cfg_prdata = {53'b0, out_size_r};
      brcn_pkg::REG_SRC_W:    cfg_prdata = {51'b0, src_w_r};
      brcn_pkg::REG_SRC_H:    cfg_prdata = {51'b0, src_h_r};
      brcn_pkg::REG_SRC_CH:   cfg_prdata = {61'b0, src_ch_r};
      brcn_pkg::REG_MEAN:     cfg_prdata = {16'b0, mean_r};
      brcn_pkg::REG_STD:      cfg_prdata = {16'b0, std_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_r   <= {{MB_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};
    oob_d_r <= !rd_in;
    unique case (state_r)
      brcn_pkg::ST_IDLE: begin
        if (in_acc && (in_req == brcn_pkg::REQ_COMPUTE)) begin
          col_r     <= in_col;
          row_r     <= in_row;
          chan_r    <= 2'd0;
          bad_r     <= in_bad;
          out_val_r <= 16'd0;
          div_r_r   <= {29'b0, w_eff, 16'b0};
          div_d_r   <= {19'b0, osz, 28'b0};
          div_q_r   <= '0;
          div_cnt_r <= 5'd29;
        end
      end
      brcn_pkg::ST_DIVX: begin
        div_r_r   <= div_rem_nxt;
        div_d_r   <= div_d_r >> 1;
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          sx_r      <= div_q_nxt;
          div_r_r   <= {29'b0, h_eff, 16'b0};
          div_d_r   <= {19'b0, osz, 28'b0};
          div_q_r   <= '0;
          div_cnt_r <= 5'd29;
        end
      end
      brcn_pkg::ST_DIVY: begin
        div_r_r   <= div_rem_nxt;
        div_d_r   <= div_d_r >> 1;
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          sy_r  <= div_q_nxt;
          cnt_r <= 4'd0;
        end
      end
      brcn_pkg::ST_MUL: begin
        cnt_r <= (cnt_r == 4'd13) ? 4'd0 : (cnt_r + 4'd1);
        unique case (cnt_r)
          4'd1: begin
            x0_r <= (xi > {10'b0, wm1}) ? wm1 : xi[12:0];
            dx_r <= mul_r[15:0];
          end
          4'd2: begin
            y0_r <= (yi > {10'b0, hm1}) ? hm1 : yi[12:0];
            dy_r <= mul_r[15:0];
          end
          4'd4:  rw0_r    <= mul_r[25:0];
          4'd5:  rw1_r    <= mul_r[25:0];
          4'd6:  wgt_r[0] <= mul_r[32:0];
          4'd7:  wgt_r[1] <= mul_r[32:0];
          4'd8:  wgt_r[2] <= mul_r[32:0];
          4'd9:  wgt_r[3] <= mul_r[32:0];
          4'd10: nb_r[0]  <= mul_r[AD_W-1:0];
          4'd11: nb_r[1]  <= mul_r[AD_W-1:0];
          4'd12: nb_r[2]  <= mul_r[AD_W-1:0];
          4'd13: nb_r[3]  <= mul_r[AD_W-1:0];
          default: ;
        endcase
      end
      brcn_pkg::ST_CH: begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd0) begin
          acc_r <= '0;
        end else if (cnt_r >= 4'd2) begin
          acc_r <= acc_r + mul_r[40:0];
        end
      end
      brcn_pkg::ST_NORM: begin
        neg_r   <= neg;
        mag0_r  <= (mag == 41'd0);
        den0_r  <= (den24 == 24'd0);
        dn_r    <= den24;
        div_r_r <= {4'b0, nsum};
      end
      brcn_pkg::ST_NCHK: begin
        if (mag0_r) begin
          out_val_r <= 16'd0;
        end else if (den0_r || nsat) begin
          out_val_r <= neg_r ? 16'h8000 : 16'h7FFF;
        end
        div_d_r   <= {2'b0, dn_r, 32'b0};
        div_q_r   <= '0;
        div_cnt_r <= 5'd17;
      end
      brcn_pkg::ST_DIVN: begin
        div_r_r   <= div_rem_nxt;
        div_d_r   <= div_d_r >> 1;
        div_q_r   <= div_q_nxt;
        div_cnt_r <= div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          out_val_r <= qval;
        end
      end
      brcn_pkg::ST_OUT: begin
        if (out_tready && (chan_r != brcn_pkg::LAST_CHAN)) begin
          chan_r <= chan_r + 2'd1;
          cnt_r  <= 4'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = (state_r == brcn_pkg::ST_OUT);
  assign out_tdata  = out_val_r;
  assign out_tuser  = {bad_r ? brcn_pkg::STATUS_RANGE : brcn_pkg::STATUS_OK, chan_r};
  assign out_tlast  = (chan_r == brcn_pkg::LAST_CHAN);

  a_bad_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req == brcn_pkg::REQ_COMPUTE) && in_bad |=> out_tvalid && out_tuser[2])
    else $error("out-of-range compute did not give a status result");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 16'd0)
    else $error("status result carries a nonzero value");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("block not idle after final channel transfer");

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

endmodule
